// ----- hw/rtl/tlcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_pkg
// shared types, register map and digit helpers for the traffic light block
// ----------------------------------------------------------------------------
package tlcc_pkg;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       lamp_t;

  localparam lamp_t LAMP_RED    = 2'd0;
  localparam lamp_t LAMP_YELLOW = 2'd1;
  localparam lamp_t LAMP_GREEN  = 2'd2;
  localparam lamp_t LAMP_DARK   = 2'd3;

  localparam logic [1:0] REG_GREEN  = 2'd0;
  localparam logic [1:0] REG_YELLOW = 2'd1;
  localparam logic [1:0] REG_RED    = 2'd2;

  localparam cnt_t GREEN_RST  = 7'd3;
  localparam cnt_t YELLOW_RST = 7'd2;
  localparam cnt_t RED_RST    = 7'd5;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_G1_R2  = 3'd1,
    PH_Y1_R2  = 3'd2,
    PH_R1_G2  = 3'd3,
    PH_R1_Y2  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    SC_INIT = 3'd0,
    SC_D0   = 3'd1,
    SC_D1   = 3'd2,
    SC_D2   = 3'd3,
    SC_D3   = 3'd4
  } scan_t;

  typedef struct packed {
    cnt_t green;
    cnt_t yellow;
    cnt_t red;
  } timing_t;

  typedef struct packed {
    cnt_t one;
    cnt_t two;
  } counts_t;

  // tens digit by reciprocal multiply, exact for values below 128
  function automatic logic [3:0] tens_of(cnt_t x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(cnt_t x);
    logic [3:0] t;
    cnt_t       r;
    t = tens_of(x);
    r = x - ({t, 3'b000} + {2'b00, t, 1'b0});
    return r[3:0];
  endfunction

endpackage

// ----- hw/rtl/tlcc_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_phase
// light phase sequencer with both road countdown counters
// ----------------------------------------------------------------------------
module tlcc_phase (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              second_tick,
  input  tlcc_pkg::timing_t timing,
  output tlcc_pkg::lamp_t   lamp1,
  output tlcc_pkg::lamp_t   lamp2,
  output tlcc_pkg::counts_t mid,
  output tlcc_pkg::counts_t fin
);

  tlcc_pkg::phase_t phase, phase_next;
  tlcc_pkg::cnt_t   count_one, count_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tlcc_pkg::PH_INIT;
      count_one <= '0;
      count_two <= '0;
    end else if (step) begin
      phase     <= phase_next;
      count_one <= fin.one;
      count_two <= fin.two;
    end
  end

  always_comb begin
    phase_next = phase;
    mid.one    = count_one;
    mid.two    = count_two;
    lamp1      = tlcc_pkg::LAMP_DARK;
    lamp2      = tlcc_pkg::LAMP_DARK;
    case (phase)
      tlcc_pkg::PH_G1_R2: begin
        lamp1 = tlcc_pkg::LAMP_GREEN;
        lamp2 = tlcc_pkg::LAMP_RED;
        if (count_one == '0) begin
          mid.one    = timing.yellow;
          mid.two    = timing.yellow;
          phase_next = tlcc_pkg::PH_Y1_R2;
        end
      end
      tlcc_pkg::PH_Y1_R2: begin
        lamp1 = tlcc_pkg::LAMP_YELLOW;
        lamp2 = tlcc_pkg::LAMP_RED;
        if (count_one == '0) begin
          mid.one    = timing.red;
          mid.two    = timing.green;
          phase_next = tlcc_pkg::PH_R1_G2;
        end
      end
      tlcc_pkg::PH_R1_G2: begin
        lamp1 = tlcc_pkg::LAMP_RED;
        lamp2 = tlcc_pkg::LAMP_GREEN;
        if (count_two == '0) begin
          mid.one    = timing.yellow;
          mid.two    = timing.yellow;
          phase_next = tlcc_pkg::PH_R1_Y2;
        end
      end
      tlcc_pkg::PH_R1_Y2: begin
        lamp1 = tlcc_pkg::LAMP_RED;
        lamp2 = tlcc_pkg::LAMP_YELLOW;
        if (count_two == '0) begin
          mid.one    = timing.green;
          mid.two    = timing.red;
          phase_next = tlcc_pkg::PH_G1_R2;
        end
      end
      default: begin
        mid.one    = timing.green;
        mid.two    = timing.red;
        phase_next = tlcc_pkg::PH_G1_R2;
      end
    endcase
  end

  // saturating countdown
  always_comb begin
    fin = mid;
    if (second_tick) begin
      if (mid.one != '0) fin.one = mid.one - 7'd1;
      if (mid.two != '0) fin.two = mid.two - 7'd1;
    end
  end

endmodule

// ----- hw/rtl/tlcc_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_scan
// four digit multiplexed readout scanner
// ----------------------------------------------------------------------------
module tlcc_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              scan_tick,
  input  tlcc_pkg::counts_t mid,
  output logic [3:0]        sel_n,
  output logic [3:0]        dig
);

  tlcc_pkg::scan_t pos, pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= tlcc_pkg::SC_INIT;
    end else if (step) begin
      pos <= pos_next;
    end
  end

  always_comb begin
    pos_next = pos;
    sel_n    = 4'hF;
    dig      = 4'd0;
    case (pos)
      tlcc_pkg::SC_D0: begin
        sel_n = 4'b1110;
        dig   = tlcc_pkg::tens_of(mid.one);
        if (scan_tick) pos_next = tlcc_pkg::SC_D1;
      end
      tlcc_pkg::SC_D1: begin
        sel_n = 4'b1101;
        dig   = tlcc_pkg::units_of(mid.one);
        if (scan_tick) pos_next = tlcc_pkg::SC_D2;
      end
      tlcc_pkg::SC_D2: begin
        sel_n = 4'b1011;
        dig   = tlcc_pkg::tens_of(mid.two);
        if (scan_tick) pos_next = tlcc_pkg::SC_D3;
      end
      tlcc_pkg::SC_D3: begin
        sel_n = 4'b0111;
        dig   = tlcc_pkg::units_of(mid.two);
        if (scan_tick) pos_next = tlcc_pkg::SC_D0;
      end
      default: begin
        pos_next = tlcc_pkg::SC_D0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/traffic_light_countdown_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_countdown_controller
// two-road light controller with countdowns and a four digit readout
// ----------------------------------------------------------------------------
// One item is one base tick carrying the second and scan flags, and it gives
// exactly one result, on the cycle after the item is taken. An item can be
// taken every clock cycle: the phase, counter and scanner update is a single
// pass of logic between the state registers and the output register. The
// output register takes the next item in the same cycle that its result is
// taken, and the input stalls only while that register is full and not taken.
// Phase timings sit in an APB register file at 0x0 (green), 0x4 (yellow) and
// 0x8 (red); write them only while the block is idle.
module traffic_light_countdown_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [tlcc_pkg::DATA_W-1:0]   pwdata,
  output logic [tlcc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          second_tick,
  input  logic                          scan_tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    road1_light,
  output logic [1:0]                    road2_light,
  output logic [3:0]                    digit_select_n,
  output logic [3:0]                    digit_value,
  output logic [6:0]                    road1_count,
  output logic [6:0]                    road2_count
);

  tlcc_pkg::timing_t timing;
  tlcc_pkg::counts_t mid, fin;
  tlcc_pkg::lamp_t   lamp1, lamp2;
  logic [3:0]        sel_n, dig;
  logic              step, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.green  <= tlcc_pkg::GREEN_RST;
      timing.yellow <= tlcc_pkg::YELLOW_RST;
      timing.red    <= tlcc_pkg::RED_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        tlcc_pkg::REG_GREEN:  timing.green  <= pwdata[6:0];
        tlcc_pkg::REG_YELLOW: timing.yellow <= pwdata[6:0];
        tlcc_pkg::REG_RED:    timing.red    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tlcc_pkg::REG_GREEN:  prdata = {25'd0, timing.green};
      tlcc_pkg::REG_YELLOW: prdata = {25'd0, timing.yellow};
      tlcc_pkg::REG_RED:    prdata = {25'd0, timing.red};
      default:              prdata = '0;
    endcase
  end

  assign in_ready = ~out_valid | out_ready;
  assign step     = in_valid & in_ready;

  tlcc_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .second_tick (second_tick),
    .timing      (timing),
    .lamp1       (lamp1),
    .lamp2       (lamp2),
    .mid         (mid),
    .fin         (fin)
  );

  tlcc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .scan_tick (scan_tick),
    .mid       (mid),
    .sel_n     (sel_n),
    .dig       (dig)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      road1_light    <= lamp1;
      road2_light    <= lamp2;
      digit_select_n <= sel_n;
      digit_value    <= dig;
      road1_count    <= fin.one;
      road2_count    <= fin.two;
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the traffic light countdown controller
// ----------------------------------------------------------------------------
// Drives base ticks carrying the second and scan flags through the valid/ready
// input channel, with bursts and gaps on the sending side and stalls of
// changing shape on the result side. Every accepted tick is run through a
// local model of the phase machine, the digit scanner and the countdowns.
// Each readout that comes back is compared with the oldest prediction. Phase
// timings are set over APB between runs of ticks and read back. The settings
// include zero, 99 and 127, and a write to an unmapped register.
// ----------------------------------------------------------------------------
module tb;
  import tlcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam logic [1:0]  REG_NONE     = 2'd3;

  typedef struct packed {
    lamp_t      l1;
    lamp_t      l2;
    logic [3:0] sel;
    logic [3:0] dig;
    cnt_t       c1;
    cnt_t       c2;
  } readout_t;

  logic              clk, rst;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              in_valid, in_ready, second_tick, scan_tick;
  logic              out_valid, out_ready;
  logic [1:0]        road1_light, road2_light;
  logic [3:0]        digit_select_n, digit_value;
  logic [6:0]        road1_count, road2_count;

  timing_t  times;
  phase_t   phase;
  scan_t    scan_pos;
  counts_t  counts;
  readout_t pending[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned readouts_checked;
  int unsigned reg_writes;
  int unsigned burst_left;
  bit          idle_on;
  int unsigned stall_mode;
  int unsigned stall_left;

  traffic_light_countdown_controller uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .second_tick(second_tick), .scan_tick(scan_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .road1_light(road1_light), .road2_light(road2_light),
    .digit_select_n(digit_select_n), .digit_value(digit_value),
    .road1_count(road1_count), .road2_count(road2_count)
  );

  always #5 clk = ~clk;

  function automatic void flag(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void reload(cnt_t a, cnt_t b, phase_t nxt);
    counts.one = a;
    counts.two = b;
    phase = nxt;
  endfunction

  function automatic readout_t advance_lights(logic sec, logic scan);
    readout_t   r;
    logic [1:0] k;
    cnt_t       src;
    r.l1  = LAMP_DARK;
    r.l2  = LAMP_DARK;
    r.sel = 4'hf;
    r.dig = 4'd0;
    case (phase)
      PH_G1_R2: begin
        r.l1 = LAMP_GREEN;
        r.l2 = LAMP_RED;
        if (counts.one == 0) reload(times.yellow, times.yellow, PH_Y1_R2);
      end
      PH_Y1_R2: begin
        r.l1 = LAMP_YELLOW;
        r.l2 = LAMP_RED;
        if (counts.one == 0) reload(times.red, times.green, PH_R1_G2);
      end
      PH_R1_G2: begin
        r.l1 = LAMP_RED;
        r.l2 = LAMP_GREEN;
        if (counts.two == 0) reload(times.yellow, times.yellow, PH_R1_Y2);
      end
      PH_R1_Y2: begin
        r.l1 = LAMP_RED;
        r.l2 = LAMP_YELLOW;
        if (counts.two == 0) reload(times.green, times.red, PH_G1_R2);
      end
      default: begin
        reload(times.green, times.red, PH_G1_R2);
      end
    endcase
    // digits come from the counters after the phase update
    if (scan_pos == SC_INIT) begin
      scan_pos = SC_D0;
    end else begin
      k     = 2'(scan_pos - SC_D0);
      src   = k[1] ? counts.two : counts.one;
      r.dig = k[0] ? 4'(src % 10) : 4'(src / 10);
      r.sel = ~(4'b0001 << k);
      if (scan) scan_pos = (scan_pos == SC_D3) ? SC_D0 : scan_t'(scan_pos + 3'd1);
    end
    if (sec) begin
      if (counts.one != 0) counts.one = counts.one - 7'd1;
      if (counts.two != 0) counts.two = counts.two - 7'd1;
    end
    r.c1 = counts.one;
    r.c2 = counts.two;
    return r;
  endfunction

  function automatic cnt_t pick_time();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 7'd0;
    if (pick == 1) return 7'd99;
    if (pick == 2) return 7'd127;
    if (pick == 3) return cnt_t'($urandom_range(0, 127));
    return cnt_t'($urandom_range(1, 6));
  endfunction

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_reg(input logic [1:0] idx, input cnt_t val);
    logic [DATA_W-1:0] unused;
    apb_access(1'b1, idx, {25'($urandom), val}, unused);
    case (idx)
      REG_GREEN:  times.green  = val;
      REG_YELLOW: times.yellow = val;
      REG_RED:    times.red    = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic check_regs();
    logic [DATA_W-1:0] got;
    apb_access(1'b0, REG_GREEN, '0, got);
    if (got !== DATA_W'(times.green))
      flag($sformatf("green read exp %0d got %0d", times.green, got));
    apb_access(1'b0, REG_YELLOW, '0, got);
    if (got !== DATA_W'(times.yellow))
      flag($sformatf("yellow read exp %0d got %0d", times.yellow, got));
    apb_access(1'b0, REG_RED, '0, got);
    if (got !== DATA_W'(times.red))
      flag($sformatf("red read exp %0d got %0d", times.red, got));
  endtask

  task automatic send_tick(input logic sec, input logic scan);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid    = 1'b1;
    second_tick = sec;
    scan_tick   = scan;
    do @(posedge clk); while (!in_ready);
    pending.push_back(advance_lights(sec, scan));
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reset values, then one full light cycle with every tick set
  task automatic test_power_up();
    int i;
    check_regs();
    for (i = 0; i < 11; i++) send_tick(1'b1, 1'b1);
  endtask

  // scanner holds its digit without a scan tick
  task automatic test_scan_hold();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  // zero durations: once the old counts run out, phase moves every tick, counters sit at zero
  task automatic test_zero_times();
    int i;
    settle();
    set_reg(REG_GREEN, 7'd0);
    set_reg(REG_YELLOW, 7'd0);
    set_reg(REG_RED, 7'd0);
    for (i = 0; i < 6; i++) send_tick(1'b1, i[0]);
  endtask

  // counts above 99 give tens digits of 10 to 12
  task automatic test_long_times();
    int i;
    settle();
    set_reg(REG_GREEN, 7'd127);
    set_reg(REG_YELLOW, 7'd99);
    set_reg(REG_RED, 7'd100);
    check_regs();
    for (i = 0; i < 6; i++) send_tick(i[1], 1'b1);
  endtask

  // unmapped register write leaves the timings alone
  task automatic test_bad_index();
    settle();
    set_reg(REG_NONE, 7'h55);
    check_regs();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, n, i, sec_pct, scan_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      set_reg(REG_GREEN, pick_time());
      set_reg(REG_YELLOW, pick_time());
      set_reg(REG_RED, pick_time());
      if ($urandom_range(0, 3) == 0) set_reg(REG_NONE, cnt_t'($urandom));
      if ($urandom_range(0, 2) == 0) check_regs();
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0:       sec_pct = 5;
        1:       sec_pct = 40;
        2:       sec_pct = 70;
        default: sec_pct = 100;
      endcase
      scan_pct = $urandom_range(0, 100);
      n = $urandom_range(60, 180);
      for (i = 0; i < n; i++)
        send_tick($urandom_range(0, 99) < sec_pct, $urandom_range(0, 99) < scan_pct);
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    readout_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{road1_light, road2_light, digit_select_n, digit_value,
              road1_count, road2_count};
      if (pending.size() == 0) begin
        flag($sformatf("readout with nothing pending: %p", got));
      end else begin
        want = pending.pop_front();
        readouts_checked++;
        if (got.l1 !== want.l1 || got.l2 !== want.l2 || got.sel !== want.sel ||
            got.dig !== want.dig || got.c1 !== want.c1 || got.c2 !== want.c2)
          flag($sformatf("readout %0d exp %p got %p", readouts_checked, want, got));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ((cycles % 7) >= 2);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d readouts pending",
               cycles, pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    second_tick = 1'b0;
    scan_tick   = 1'b0;
    out_ready   = 1'b1;
    stall_mode  = 0;
    stall_left  = 0;
    burst_left  = 0;
    idle_on     = 1'b1;
    cycles      = 0;
    errors      = 0;
    items_sent  = 0;
    readouts_checked = 0;
    reg_writes  = 0;
    times       = '{GREEN_RST, YELLOW_RST, RED_RST};
    phase       = PH_INIT;
    scan_pos    = SC_INIT;
    counts      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_power_up();
    test_scan_hold();
    test_zero_times();
    test_long_times();
    test_bad_index();
    test_random_traffic();
    settle();

    errors += pending.size();
    $display("%0d ticks sent, %0d readouts checked, %0d register writes, %0d cycles",
             items_sent, readouts_checked, reg_writes, cycles);
    $display("timings from 0 to 127 across all four phases, %0d mismatches", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tlcc_pkg.sv
hw/rtl/tlcc_phase.sv
hw/rtl/tlcc_scan.sv
hw/rtl/traffic_light_countdown_controller.sv
bench/tb.sv
